### hw/rtl/rop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rop_pkg
// Types and constants shared by the render override message parser.
// ---------------------------------------------------------------------------
package rop_pkg;

  typedef enum logic [3:0] {
    PH_SETMASK   = 4'd0,
    PH_RESETMASK = 4'd1,
    PH_MODEFX    = 4'd2,
    PH_AMOUNT    = 4'd3,
    PH_COLOUR    = 4'd4,
    PH_SKIN      = 4'd5,
    PH_BODY      = 4'd6,
    PH_TAIL      = 4'd7
  } phase_t;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic CFG_MAX_MODE   = 1'b0;
  localparam logic CFG_MAX_EFFECT = 1'b1;

  localparam logic [2:0]  MAX_MODE_RST   = 3'd5;
  localparam logic [4:0]  MAX_EFFECT_RST = 5'd20;
  localparam logic [31:0] BODY_ALL_ONES  = 32'hFFFF_FFFF;

  localparam int unsigned OVR_W = 6;

  typedef struct packed {
    logic [2:0]       render_mode;
    logic [4:0]       render_effect;
    logic [7:0]       render_amount;
    logic [7:0]       color_red;
    logic [7:0]       color_green;
    logic [7:0]       color_blue;
    logic [7:0]       skin_number;
    logic [31:0]      body_value;
    logic [OVR_W-1:0] override_mask;
    logic             message_done;
    logic             truncated;
  } rop_result_t;

  // first field phase at or after from whose field is expected, else tail
  function automatic phase_t next_phase(input phase_t from, input logic [OVR_W-1:0] s);
    phase_t p;
    p = PH_TAIL;
    if (from <= PH_MODEFX && s[1:0] != 2'b00) begin
      p = PH_MODEFX;
    end else if (from <= PH_AMOUNT && s[2]) begin
      p = PH_AMOUNT;
    end else if (from <= PH_COLOUR && s[3]) begin
      p = PH_COLOUR;
    end else if (from <= PH_SKIN && s[4]) begin
      p = PH_SKIN;
    end else if (from <= PH_BODY && s[5]) begin
      p = PH_BODY;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rop_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rop_parser
// Parse state and stored overrides; computes the result of one item in a
// single pass and commits the state when the item advances.
// ---------------------------------------------------------------------------
module rop_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 op,
  input  wire logic [7:0]           byte_value,
  input  wire logic [2:0]           max_mode,
  input  wire logic [4:0]           max_effect,
  output rop_pkg::rop_result_t      result
);
  import rop_pkg::*;

  phase_t           phase_r,   phase_nxt;
  logic [OVR_W-1:0] set_r,     set_nxt;
  logic [OVR_W-1:0] rst_r,     rst_nxt;
  logic [1:0]       pos_r,     pos_nxt;
  logic [31:0]      gather_r,  gather_nxt;
  logic [2:0]       mode_r,    mode_nxt;
  logic [4:0]       effect_r,  effect_nxt;
  logic [7:0]       amount_r,  amount_nxt;
  logic [23:0]      colour_r,  colour_nxt;
  logic [7:0]       skin_r,    skin_nxt;
  logic [31:0]      body_r,    body_nxt;
  logic [OVR_W-1:0] valid_r,   valid_nxt;

  logic [OVR_W-1:0] es;
  logic [OVR_W-1:0] mk_set;
  logic [OVR_W-1:0] mk_rst;
  logic [OVR_W-1:0] mk_es;
  logic             mk_done;
  logic [31:0]      gather_add;
  logic             done;
  logic             trunc;
  logic             clr;

  assign es     = set_r & ~rst_r;
  assign mk_set = (phase_r == PH_SETMASK) ? byte_value[5:0] : set_r;
  assign mk_rst = (phase_r == PH_SETMASK) ? '0 : byte_value[5:0];
  assign mk_es  = mk_set & ~mk_rst;

  always_comb begin
    gather_add = gather_r;
    case (pos_r)
      2'd0: gather_add[7:0]   = gather_r[7:0]   | byte_value;
      2'd1: gather_add[15:8]  = gather_r[15:8]  | byte_value;
      2'd2: gather_add[23:16] = gather_r[23:16] | byte_value;
      default: gather_add[31:24] = gather_r[31:24] | byte_value;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    set_nxt    = set_r;
    rst_nxt    = rst_r;
    pos_nxt    = pos_r;
    gather_nxt = gather_r;
    mode_nxt   = mode_r;
    effect_nxt = effect_r;
    amount_nxt = amount_r;
    colour_nxt = colour_r;
    skin_nxt   = skin_r;
    body_nxt   = body_r;
    valid_nxt  = valid_r;
    done       = 1'b0;
    trunc      = 1'b0;
    clr        = 1'b0;
    mk_done    = 1'b0;
    if (step) begin
      if (op == OP_END) begin
        done       = 1'b1;
        clr        = (phase_r != PH_TAIL);
        phase_nxt  = PH_SETMASK;
        set_nxt    = '0;
        rst_nxt    = '0;
        pos_nxt    = '0;
        gather_nxt = '0;
      end else begin
        unique case (phase_r)
          PH_SETMASK: begin
            set_nxt = byte_value[5:0];
            rst_nxt = '0;
            if (byte_value[6]) begin
              phase_nxt = PH_RESETMASK;
            end else begin
              mk_done = 1'b1;
            end
          end
          PH_RESETMASK: begin
            rst_nxt = byte_value[5:0];
            mk_done = 1'b1;
          end
          PH_MODEFX: begin
            if (es[0]) begin
              mode_nxt     = (byte_value[2:0] > max_mode) ? max_mode : byte_value[2:0];
              valid_nxt[0] = 1'b1;
            end
            if (es[1]) begin
              effect_nxt   = (byte_value[7:3] > max_effect) ? max_effect : byte_value[7:3];
              valid_nxt[1] = 1'b1;
            end
            phase_nxt = next_phase(PH_AMOUNT, es);
          end
          PH_AMOUNT: begin
            amount_nxt   = byte_value;
            valid_nxt[2] = 1'b1;
            phase_nxt    = next_phase(PH_COLOUR, es);
          end
          PH_COLOUR: begin
            gather_nxt = gather_add;
            if (pos_r >= 2'd2) begin
              colour_nxt   = gather_add[23:0];
              valid_nxt[3] = 1'b1;
              gather_nxt   = '0;
              pos_nxt      = '0;
              phase_nxt    = next_phase(PH_SKIN, es);
            end else begin
              pos_nxt = pos_r + 2'd1;
            end
          end
          PH_SKIN: begin
            skin_nxt     = byte_value;
            valid_nxt[4] = 1'b1;
            phase_nxt    = next_phase(PH_BODY, es);
          end
          PH_BODY: begin
            gather_nxt = gather_add;
            if (pos_r == 2'd3) begin
              if (gather_add == BODY_ALL_ONES) begin
                clr = 1'b1;
              end else begin
                body_nxt     = gather_add;
                valid_nxt[5] = 1'b1;
              end
              gather_nxt = '0;
              pos_nxt    = '0;
              phase_nxt  = PH_TAIL;
            end else begin
              pos_nxt = pos_r + 2'd1;
            end
          end
          default: begin
            phase_nxt = PH_TAIL;
          end
        endcase
      end
      if (mk_done) begin
        if (mk_es[1:0] == 2'b00) begin
          valid_nxt[1:0] = valid_r[1:0] & ~mk_rst[1:0];
        end
        valid_nxt[5:2] = valid_r[5:2] & ~mk_rst[5:2];
        pos_nxt        = '0;
        gather_nxt     = '0;
        phase_nxt      = next_phase(PH_MODEFX, mk_es);
      end
      if (clr) begin
        trunc      = 1'b1;
        mode_nxt   = '0;
        effect_nxt = '0;
        amount_nxt = '0;
        colour_nxt = '0;
        skin_nxt   = '0;
        body_nxt   = '0;
        valid_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SETMASK;
      set_r    <= '0;
      rst_r    <= '0;
      pos_r    <= '0;
      gather_r <= '0;
      mode_r   <= '0;
      effect_r <= '0;
      amount_r <= '0;
      colour_r <= '0;
      skin_r   <= '0;
      body_r   <= '0;
      valid_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      set_r    <= set_nxt;
      rst_r    <= rst_nxt;
      pos_r    <= pos_nxt;
      gather_r <= gather_nxt;
      mode_r   <= mode_nxt;
      effect_r <= effect_nxt;
      amount_r <= amount_nxt;
      colour_r <= colour_nxt;
      skin_r   <= skin_nxt;
      body_r   <= body_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_comb begin
    result.render_mode   = mode_nxt;
    result.render_effect = effect_nxt;
    result.render_amount = amount_nxt;
    result.color_red     = colour_nxt[7:0];
    result.color_green   = colour_nxt[15:8];
    result.color_blue    = colour_nxt[23:16];
    result.skin_number   = skin_nxt;
    result.body_value    = body_nxt;
    result.override_mask = valid_nxt;
    result.message_done  = done;
    result.truncated     = trunc;
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && op == OP_END) |=> (phase_r == PH_SETMASK && pos_r == 2'd0))
    else $error("end item did not restart the parse");

  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_COLOUR && phase_r != PH_BODY) |-> (pos_r == 2'd0))
    else $error("byte position set outside a multi-byte field");

  a_colour_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COLOUR) |-> (pos_r != 2'd3))
    else $error("colour byte position out of range");

  a_trunc_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && trunc) |=> (valid_r == '0 && body_r == '0 && mode_r == '0))
    else $error("truncation left overrides in place");

endmodule
`default_nettype wire

### hw/rtl/render_override_message_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// render_override_message_parser_unit
// Byte-wise parser of render override messages with stored override values.
//
//   channel | dir | payload
//   --------+-----+---------------------------------------------------------
//   in_     | in  | tdata = byte_value, tuser = op (1 = end of message)
//   out_    | out | tdata = stored overrides and mask, tlast = message_done,
//           |     | tuser = truncated
//   cfg_    | in  | index 0 = max_render_mode, 1 = max_render_effect
//
// one item per cycle sustained while out_tready stays high; an item passes
// through the input register, then the result register
// parse state commits when an item moves from the input register into the
// result register
// synchronous active-low reset clears parse state and overrides and restores the limits to their reset values
// a stalled result holds a full input register, which then drops in_tready
// ---------------------------------------------------------------------------
module render_override_message_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tuser,   // [0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // mode, effect, amount, red, green, blue,
                                       // skin, body, override_mask, 2 zero bits
  output logic             out_tlast,  // message_done
  output logic             out_tuser,  // [0] truncated
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import rop_pkg::*;

  logic        s1_valid_r;
  logic        s1_op_r;
  logic [7:0]  s1_byte_r;
  logic        s1_adv;
  logic        out_valid_r;
  rop_result_t out_r;
  rop_result_t res;
  logic [2:0]  max_mode_r;
  logic [4:0]  max_effect_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  rop_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .op         (s1_op_r),
    .byte_value (s1_byte_r),
    .max_mode   (max_mode_r),
    .max_effect (max_effect_r),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mode_r   <= MAX_MODE_RST;
      max_effect_r <= MAX_EFFECT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_MODE:   max_mode_r   <= cfg_data[2:0];
        CFG_MAX_EFFECT: max_effect_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.override_mask, out_r.body_value, out_r.skin_number,
                       out_r.color_blue, out_r.color_green, out_r.color_red,
                       out_r.render_amount, out_r.render_effect, out_r.render_mode};
  assign out_tlast  = out_r.message_done;
  assign out_tuser  = out_r.truncated;

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item did not reach the result register");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !s1_adv)
    else $error("result overwritten while stalled");

  a_stall_holds_in: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while the input register is full and stalled");

endmodule
`default_nettype wire

### bench/render_override_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// render_override_checker
// Watches the byte, result and limit channels of the render override parser,
// keeps its own copy of the parse state and overrides, predicts one result
// per accepted byte or end marker and compares every result field by field.
// ---------------------------------------------------------------------------
module render_override_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [87:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        out_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  output int               n_errors,
  output int               n_waiting,
  output int               n_checked,
  output int               n_cleared
);
  import rop_pkg::*;

  logic [2:0]  mode_cap;
  logic [4:0]  effect_cap;

  phase_t      phase_q;
  logic [5:0]  set_q;
  logic [5:0]  rst_q;
  logic [1:0]  pos_q;
  logic [31:0] gather_q;
  logic [2:0]  mode_q;
  logic [4:0]  effect_q;
  logic [7:0]  amount_q;
  logic [23:0] colour_q;
  logic [7:0]  skin_q;
  logic [31:0] body_q;
  logic [5:0]  flags_q;

  rop_result_t pending_overrides[$];
  rop_result_t want;
  rop_result_t got;

  // next field phase from a given point that the live mask still asks for
  function automatic phase_t first_wanted(input phase_t from);
    logic [5:0] live;
    logic       hit;
    int         k;
    live = set_q & ~rst_q;
    for (k = int'(from); k <= int'(PH_BODY); k++) begin
      case (phase_t'(k))
        PH_MODEFX: hit = |live[1:0];
        PH_AMOUNT: hit = live[2];
        PH_COLOUR: hit = live[3];
        PH_SKIN:   hit = live[4];
        PH_BODY:   hit = live[5];
        default:   hit = 1'b0;
      endcase
      if (hit) return phase_t'(k);
    end
    return PH_TAIL;
  endfunction

  task automatic wipe_overrides();
    mode_q   = '0;
    effect_q = '0;
    amount_q = '0;
    colour_q = '0;
    skin_q   = '0;
    body_q   = '0;
    flags_q  = '0;
  endtask

  task automatic close_masks();
    // mode and effect resets only count when neither is still set
    if ((set_q[1:0] & ~rst_q[1:0]) == 2'b00) begin
      flags_q[1:0] = flags_q[1:0] & ~rst_q[1:0];
    end
    flags_q[5:2] = flags_q[5:2] & ~rst_q[5:2];
    pos_q    = '0;
    gather_q = '0;
    phase_q  = first_wanted(PH_MODEFX);
  endtask

  task automatic parse_byte(input logic op, input logic [7:0] b, output rop_result_t r);
    logic [5:0]  live;
    logic [31:0] word;
    logic        cleared;
    cleared = 1'b0;
    live    = set_q & ~rst_q;
    word    = gather_q | ({24'b0, b} << (8 * pos_q));
    if (op == OP_END) begin
      if (phase_q != PH_TAIL) begin
        wipe_overrides();
        cleared = 1'b1;
      end
      phase_q  = PH_SETMASK;
      set_q    = '0;
      rst_q    = '0;
      pos_q    = '0;
      gather_q = '0;
    end else begin
      case (phase_q)
        PH_SETMASK: begin
          set_q = b[5:0];
          rst_q = '0;
          if (b[6]) begin
            phase_q = PH_RESETMASK;
          end else begin
            close_masks();
          end
        end
        PH_RESETMASK: begin
          rst_q = b[5:0];
          close_masks();
        end
        PH_MODEFX: begin
          if (live[0]) begin
            mode_q     = (b[2:0] > mode_cap) ? mode_cap : b[2:0];
            flags_q[0] = 1'b1;
          end
          if (live[1]) begin
            effect_q   = (b[7:3] > effect_cap) ? effect_cap : b[7:3];
            flags_q[1] = 1'b1;
          end
          phase_q = first_wanted(PH_AMOUNT);
        end
        PH_AMOUNT: begin
          amount_q   = b;
          flags_q[2] = 1'b1;
          phase_q    = first_wanted(PH_COLOUR);
        end
        PH_COLOUR: begin
          if (pos_q >= 2'd2) begin
            colour_q   = word[23:0];
            flags_q[3] = 1'b1;
            gather_q   = '0;
            pos_q      = '0;
            phase_q    = first_wanted(PH_SKIN);
          end else begin
            gather_q = word;
            pos_q    = pos_q + 2'd1;
          end
        end
        PH_SKIN: begin
          skin_q     = b;
          flags_q[4] = 1'b1;
          phase_q    = first_wanted(PH_BODY);
        end
        PH_BODY: begin
          if (pos_q == 2'd3) begin
            // an all-ones body word wipes everything instead of storing
            if (word == BODY_ALL_ONES) begin
              wipe_overrides();
              cleared = 1'b1;
            end else begin
              body_q     = word;
              flags_q[5] = 1'b1;
            end
            gather_q = '0;
            pos_q    = '0;
            phase_q  = PH_TAIL;
          end else begin
            gather_q = word;
            pos_q    = pos_q + 2'd1;
          end
        end
        default: begin
          phase_q = PH_TAIL;
        end
      endcase
    end
    r.render_mode   = mode_q;
    r.render_effect = effect_q;
    r.render_amount = amount_q;
    r.color_red     = colour_q[7:0];
    r.color_green   = colour_q[15:8];
    r.color_blue    = colour_q[23:16];
    r.skin_number   = skin_q;
    r.body_value    = body_q;
    r.override_mask = flags_q;
    r.message_done  = (op == OP_END);
    r.truncated     = cleared;
  endtask

  task automatic compare_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_cap   = MAX_MODE_RST;
      effect_cap = MAX_EFFECT_RST;
      phase_q    = PH_SETMASK;
      set_q      = '0;
      rst_q      = '0;
      pos_q      = '0;
      gather_q   = '0;
      wipe_overrides();
      pending_overrides.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_MODE) begin
          mode_cap = cfg_data[2:0];
        end else begin
          effect_cap = cfg_data[4:0];
        end
      end
      if (out_tvalid && out_tready) begin
        got.render_mode   = out_tdata[2:0];
        got.render_effect = out_tdata[7:3];
        got.render_amount = out_tdata[15:8];
        got.color_red     = out_tdata[23:16];
        got.color_green   = out_tdata[31:24];
        got.color_blue    = out_tdata[39:32];
        got.skin_number   = out_tdata[47:40];
        got.body_value    = out_tdata[79:48];
        got.override_mask = out_tdata[85:80];
        got.message_done  = out_tlast;
        got.truncated     = out_tuser;
        if (pending_overrides.size() == 0) begin
          $error("result item arrived with no byte waiting for it");
          n_errors++;
        end else begin
          want = pending_overrides.pop_front();
          compare_field("render_mode", want.render_mode, got.render_mode);
          compare_field("render_effect", want.render_effect, got.render_effect);
          compare_field("render_amount", want.render_amount, got.render_amount);
          compare_field("color_red", want.color_red, got.color_red);
          compare_field("color_green", want.color_green, got.color_green);
          compare_field("color_blue", want.color_blue, got.color_blue);
          compare_field("skin_number", want.skin_number, got.skin_number);
          compare_field("body_value", want.body_value, got.body_value);
          compare_field("override_mask", want.override_mask, got.override_mask);
          compare_field("message_done", want.message_done, got.message_done);
          compare_field("truncated", want.truncated, got.truncated);
          n_checked++;
          if (want.truncated) n_cleared++;
        end
      end
      if (in_tvalid && in_tready) begin
        parse_byte(in_tuser, in_tdata, want);
        pending_overrides.push_back(want);
      end
    end
    n_waiting = pending_overrides.size();
  end

endmodule

### bench/tb_render_override_message_parser_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_render_override_message_parser_unit
// Feeds render override messages byte by byte: a short directed set, then
// mostly well-formed random messages with short, noisy and padded ones mixed
// in, under several clamp settings and idle mixes; the checker judges results.
// ---------------------------------------------------------------------------
module tb_render_override_message_parser_unit;
  import rop_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int SEG_ITEMS   = 205;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = OP_DATA;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = CFG_MAX_MODE;
  logic [7:0]  cfg_data   = '0;

  int n_errors;
  int n_waiting;
  int n_checked;
  int n_cleared;

  int send_gap  = 31;
  int recv_gap  = 55;
  int hold_ask  = 0;
  int hold_done = 0;
  int hold_left;
  int cycle_count = 0;
  int n_items     = 0;
  int n_messages  = 0;
  int n_settings  = 0;

  render_override_message_parser_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  render_override_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .n_errors   (n_errors),
    .n_waiting  (n_waiting),
    .n_checked  (n_checked),
    .n_cleared  (n_cleared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random back-pressure, or a long hold when asked
  always @(posedge clk) begin
    if (hold_done != hold_ask) begin
      out_tready <= 1'b0;
      for (hold_left = HOLD_CYCLES; hold_left > 1; hold_left--) @(posedge clk);
      hold_done <= hold_done + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap);
    end
  end

  function automatic logic [7:0] rand_byte();
    return $urandom_range(255);
  endfunction

  task automatic push_item(input logic op, input logic [7:0] b);
    if ($urandom_range(99) < send_gap) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
  endtask

  // stop offering and let every outstanding result drain
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (n_waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_limits(input logic [2:0] mode_lim, input logic [4:0] fx_lim);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_MODE;
    cfg_data  <= (rand_byte() & 8'hF8) | {5'b0, mode_lim};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MAX_EFFECT;
    cfg_data  <= (rand_byte() & 8'hE0) | {3'b0, fx_lim};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic send_message();
    logic [8:0]  bytes_q[$];
    logic [7:0]  setm;
    logic [7:0]  rstm;
    logic [5:0]  live;
    logic [31:0] body;
    int          style;
    int          cut;
    int          k;
    style = $urandom_range(99);
    setm  = rand_byte();
    rstm  = rand_byte() & rand_byte() & rand_byte();
    live  = setm[5:0] & (setm[6] ? ~rstm[5:0] : 6'h3F);
    bytes_q.push_back({OP_DATA, setm});
    if (setm[6]) bytes_q.push_back({OP_DATA, rstm});
    if (|live[1:0]) bytes_q.push_back({OP_DATA, rand_byte()});
    if (live[2]) bytes_q.push_back({OP_DATA, rand_byte()});
    if (live[3]) begin
      repeat (3) bytes_q.push_back({OP_DATA, rand_byte()});
    end
    if (live[4]) bytes_q.push_back({OP_DATA, rand_byte()});
    if (live[5]) begin
      body = ($urandom_range(99) < 10) ? BODY_ALL_ONES : $urandom;
      for (k = 0; k < 4; k++) bytes_q.push_back({OP_DATA, body[8*k +: 8]});
    end
    if (style < 12) begin
      // message cut short somewhere before its last byte
      cut = $urandom_range(bytes_q.size() - 1, 0);
      while (bytes_q.size() > cut) void'(bytes_q.pop_back());
    end else if (style < 16) begin
      bytes_q.delete();
      repeat ($urandom_range(6, 0)) bytes_q.push_back({1'($urandom_range(1)), rand_byte()});
    end else if (style < 36) begin
      repeat ($urandom_range(3, 1)) bytes_q.push_back({OP_DATA, rand_byte()});
    end
    bytes_q.push_back({OP_END, rand_byte()});
    foreach (bytes_q[i]) push_item(bytes_q[i][8], bytes_q[i][7:0]);
    n_messages++;
  endtask

  initial begin : stimulus
    int         seg;
    int         seg_start;
    logic       hold_sent;
    logic       pause_done;
    logic [2:0] mode_lim;
    logic [4:0] fx_lim;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message
    push_item(OP_END, 8'h00);
    // every field, reserved bits set, clamps at reset limits, one extra byte
    push_item(OP_DATA, 8'hFF);
    push_item(OP_DATA, 8'hC0);
    push_item(OP_DATA, 8'hFF);
    push_item(OP_DATA, 8'hFF);
    push_item(OP_DATA, 8'h00);
    push_item(OP_DATA, 8'hFF);
    push_item(OP_DATA, 8'h80);
    push_item(OP_DATA, 8'h00);
    push_item(OP_DATA, 8'h01);
    push_item(OP_DATA, 8'h02);
    push_item(OP_DATA, 8'h03);
    push_item(OP_DATA, 8'h80);
    push_item(OP_DATA, 8'hAA);
    push_item(OP_END, 8'hFF);
    // effect still set, so the mode reset is ignored
    push_item(OP_DATA, 8'h43);
    push_item(OP_DATA, 8'h01);
    push_item(OP_DATA, 8'h00);
    push_item(OP_END, 8'h00);
    // all-ones body wipes everything
    push_item(OP_DATA, 8'h20);
    repeat (4) push_item(OP_DATA, 8'hFF);
    push_item(OP_END, 8'h00);

    for (seg = 0; seg < 6; seg++) begin
      settle();
      send_gap = (seg < 2) ? 31 : (seg < 4) ? 55 : 0;
      recv_gap <= (seg < 2) ? 55 : (seg < 4) ? 31 : 0;
      case (seg)
        0: begin mode_lim = 3'd7; fx_lim = 5'd31; end
        1: begin mode_lim = 3'd0; fx_lim = 5'd0; end
        3: begin mode_lim = 3'd7; fx_lim = 5'd0; end
        5: begin mode_lim = 3'd0; fx_lim = 5'd31; end
        default: begin
          mode_lim = $urandom_range(7);
          fx_lim   = $urandom_range(31);
        end
      endcase
      apply_limits(mode_lim, fx_lim);
      seg_start  = n_items;
      hold_sent  = 1'b0;
      pause_done = 1'b0;
      while (n_items - seg_start < SEG_ITEMS) begin
        send_message();
        if ((seg == 0 || seg == 4) && !hold_sent && n_items - seg_start > 60) begin
          hold_ask  <= hold_ask + 1;
          hold_sent  = 1'b1;
        end
        if (seg == 2 && !pause_done && n_items - seg_start > 100) begin
          settle();
          pause_done = 1'b1;
        end
      end
    end
    settle();
    repeat (6) @(posedge clk);

    $display("sent %0d items in %0d messages under %0d limit settings and three idle mixes",
             n_items, n_messages, n_settings);
    $display("checked %0d results, %0d of them wiped all overrides", n_checked, n_cleared);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### render_override_message_parser_unit.f
hw/rtl/rop_pkg.sv
hw/rtl/rop_parser.sv
hw/rtl/render_override_message_parser_unit.sv
bench/render_override_checker.sv
bench/tb_render_override_message_parser_unit.sv
